[src/qfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package qfs_pkg;

    localparam logic [7:0] SEMI  = 8'h3B;
    localparam logic [7:0] QUOTE = 8'h22;

    localparam logic [1:0] KIND_CONTENT   = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_LINE_END  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_COUNT    = 2'd1;
    localparam logic [1:0] STATUS_NO_DELIM = 2'd2;

    localparam int NUM_SLOTS = 6;
    localparam int SLOT_BITS = 3;

    localparam int SLOT_PEND_HELD = 0;
    localparam int SLOT_PEND_END  = 1;
    localparam int SLOT_LAST_HELD = 2;
    localparam int SLOT_LAST_END  = 3;
    localparam int SLOT_TAIL      = 4;
    localparam int SLOT_LINE_END  = 5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] field_index;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        t_result [NUM_SLOTS-1:0] slot;
        logic [NUM_SLOTS-1:0]    mask;
    } t_bundle;

    typedef struct packed {
        logic [7:0] prev;
        logic       in_quoted;
        logic       quote_follow;
        logic [7:0] held;
        logic       held_valid;
    } t_dec_state;

    typedef struct packed {
        t_dec_state st;
        logic       flush_valid;
        logic [7:0] flush_byte;
        logic       field_end;
    } t_dec_out;

    localparam t_dec_state DEC_RESET = '{
        prev:         SEMI,
        in_quoted:    1'b0,
        quote_follow: 1'b0,
        held:         8'h00,
        held_valid:   1'b0
    };

    localparam t_result RESULT_ZERO = '{
        kind:        KIND_CONTENT,
        data_byte:   8'h00,
        field_index: 8'h00,
        status:      STATUS_OK
    };

    function automatic t_dec_out decide(input t_dec_state s, input logic [7:0] c,
                                        input logic [7:0] nxt, input logic nxt_end);
        logic     semi_after;
        logic     delim;
        t_dec_out r;
        semi_after = nxt_end || (nxt == SEMI);
        if (s.quote_follow) begin
            delim = (c == QUOTE) && s.in_quoted && semi_after;
        end else begin
            delim = (c == QUOTE) && ((s.prev == SEMI) || semi_after);
        end
        r              = '0;
        r.st           = s;
        r.st.prev      = c;
        r.st.quote_follow = delim;
        r.flush_byte   = s.held;
        if (delim) begin
            r.st.in_quoted = !s.in_quoted;
        end else begin
            r.flush_valid = s.held_valid;
            if ((c == SEMI) && !s.in_quoted) begin
                r.field_end     = 1'b1;
                r.st.held_valid = 1'b0;
            end else begin
                r.st.held       = c;
                r.st.held_valid = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/qfs_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface qfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       end_of_line;

    modport source (output valid, output line_byte, output end_of_line, input ready);
    modport sink   (input valid, input line_byte, input end_of_line, output ready);
endinterface

interface qfs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] field_index;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output kind, output data_byte, output field_index,
                    output status, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input field_index,
                    input status, input last, output ready);
endinterface

`default_nettype wire

[src/qfs_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module qfs_core #(
    parameter int FIELD_INDEX_BITS = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_wr_en,
    input  wire  [7:0]          i_cfg_wr_data,
    input  wire                 i_accept,
    input  wire  [7:0]          i_line_byte,
    input  wire                 i_end_of_line,
    output qfs_pkg::t_bundle    o_bundle
);

    localparam int                    FIB     = FIELD_INDEX_BITS;
    localparam int                    CW      = (FIB > 8) ? FIB : 8;
    localparam logic [FIB-1:0]        FC_MAX  = {FIB{1'b1}};

    logic [7:0]          r_expected;
    logic [7:0]          r_pend_byte;
    logic                r_pend_valid;
    logic                r_skip;
    qfs_pkg::t_dec_state r_dec;
    logic [FIB-1:0]      r_fc;

    logic [7:0]          n_pend_byte;
    logic                n_pend_valid;
    logic                n_skip;
    qfs_pkg::t_dec_state n_dec;
    logic [FIB-1:0]      n_fc;

    qfs_pkg::t_dec_out   d1;
    qfs_pkg::t_dec_out   d2;
    qfs_pkg::t_dec_state s1;
    logic                fe1;
    logic                fl1;
    logic [FIB-1:0]      fc1;
    logic [FIB-1:0]      fc2;
    logic [FIB-1:0]      count;
    logic [1:0]          line_status;

    function automatic logic [FIB-1:0] sat_inc(input logic [FIB-1:0] v);
        return (v == FC_MAX) ? v : v + FIB'(1);
    endfunction

    function automatic logic [7:0] to_index(input logic [FIB-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        return w[7:0];
    endfunction

    function automatic qfs_pkg::t_result mk(input logic [1:0] kind, input logic [7:0] data,
                                            input logic [FIB-1:0] fc, input logic [1:0] st);
        qfs_pkg::t_result r;
        r.kind        = kind;
        r.data_byte   = data;
        r.field_index = to_index(fc);
        r.status      = st;
        return r;
    endfunction

    always_comb begin
        d1  = qfs_pkg::decide(r_dec, r_pend_byte, i_line_byte, 1'b0);
        fe1 = r_pend_valid && d1.field_end;
        fl1 = r_pend_valid && d1.flush_valid;
        s1  = r_pend_valid ? d1.st : r_dec;
        fc1 = fe1 ? sat_inc(r_fc) : r_fc;
        d2  = qfs_pkg::decide(s1, i_line_byte, 8'h00, 1'b1);
        fc2 = d2.field_end ? sat_inc(fc1) : fc1;
        count = (fc2 == FC_MAX) ? FC_MAX : fc2 + FIB'(1);
        line_status = (CW'(count) == CW'(r_expected)) ? qfs_pkg::STATUS_OK
                                                      : qfs_pkg::STATUS_COUNT;
    end

    always_comb begin
        o_bundle      = '0;
        for (int i = 0; i < qfs_pkg::NUM_SLOTS; i++) begin
            o_bundle.slot[i] = qfs_pkg::RESULT_ZERO;
        end
        n_pend_byte  = r_pend_byte;
        n_pend_valid = r_pend_valid;
        n_skip       = r_skip;
        n_dec        = r_dec;
        n_fc         = r_fc;
        if (r_skip) begin
            if (i_line_byte == qfs_pkg::SEMI) begin
                n_skip     = 1'b0;
                n_dec.prev = qfs_pkg::SEMI;
            end
            if (i_end_of_line) begin
                o_bundle.mask[qfs_pkg::SLOT_LINE_END] = 1'b1;
                o_bundle.slot[qfs_pkg::SLOT_LINE_END] = mk(qfs_pkg::KIND_LINE_END, 8'h00,
                    '0, (i_line_byte != qfs_pkg::SEMI) ? qfs_pkg::STATUS_NO_DELIM :
                        (r_expected == 8'd1) ? qfs_pkg::STATUS_OK : qfs_pkg::STATUS_COUNT);
            end
        end else begin
            o_bundle.mask[qfs_pkg::SLOT_PEND_HELD] = fl1;
            o_bundle.slot[qfs_pkg::SLOT_PEND_HELD] =
                mk(qfs_pkg::KIND_CONTENT, d1.flush_byte, r_fc, qfs_pkg::STATUS_OK);
            o_bundle.mask[qfs_pkg::SLOT_PEND_END] = fe1;
            o_bundle.slot[qfs_pkg::SLOT_PEND_END] =
                mk(qfs_pkg::KIND_FIELD_END, 8'h00, r_fc, qfs_pkg::STATUS_OK);
            if (i_end_of_line) begin
                o_bundle.mask[qfs_pkg::SLOT_LAST_HELD] = d2.flush_valid;
                o_bundle.slot[qfs_pkg::SLOT_LAST_HELD] =
                    mk(qfs_pkg::KIND_CONTENT, d2.flush_byte, fc1, qfs_pkg::STATUS_OK);
                o_bundle.mask[qfs_pkg::SLOT_LAST_END] = d2.field_end;
                o_bundle.slot[qfs_pkg::SLOT_LAST_END] =
                    mk(qfs_pkg::KIND_FIELD_END, 8'h00, fc1, qfs_pkg::STATUS_OK);
                o_bundle.mask[qfs_pkg::SLOT_TAIL] = d2.st.held_valid && !d2.st.in_quoted;
                o_bundle.slot[qfs_pkg::SLOT_TAIL] =
                    mk(qfs_pkg::KIND_CONTENT, d2.st.held, fc2, qfs_pkg::STATUS_OK);
                o_bundle.mask[qfs_pkg::SLOT_LINE_END] = 1'b1;
                o_bundle.slot[qfs_pkg::SLOT_LINE_END] =
                    mk(qfs_pkg::KIND_LINE_END, 8'h00, fc2, line_status);
            end else begin
                n_dec        = s1;
                n_fc         = fc1;
                n_pend_byte  = i_line_byte;
                n_pend_valid = 1'b1;
            end
        end
        if (i_end_of_line) begin
            n_pend_byte  = 8'h00;
            n_pend_valid = 1'b0;
            n_skip       = 1'b1;
            n_dec        = qfs_pkg::DEC_RESET;
            n_fc         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected   <= 8'd1;
            r_pend_byte  <= 8'h00;
            r_pend_valid <= 1'b0;
            r_skip       <= 1'b1;
            r_dec        <= qfs_pkg::DEC_RESET;
            r_fc         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_expected <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_pend_byte  <= n_pend_byte;
                r_pend_valid <= n_pend_valid;
                r_skip       <= n_skip;
                r_dec        <= n_dec;
                r_fc         <= n_fc;
            end
        end
    end

endmodule

`default_nettype wire

[src/qfs_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module qfs_out (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  qfs_pkg::t_bundle  i_bundle,
    output logic              o_can_load,
    qfs_out_if.source         o_out
);

    qfs_pkg::t_result [qfs_pkg::NUM_SLOTS-1:0] r_slot;
    logic [qfs_pkg::NUM_SLOTS-1:0]             r_mask;

    logic [qfs_pkg::SLOT_BITS-1:0]             sel;
    logic                                      found;
    logic [qfs_pkg::NUM_SLOTS-1:0]             mask_clr;
    logic                                      fire;
    logic                                      is_last;

    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < qfs_pkg::NUM_SLOTS; i++) begin
            if (r_mask[i] && !found) begin
                sel   = qfs_pkg::SLOT_BITS'(i);
                found = 1'b1;
            end
        end
        mask_clr = r_mask & ~(qfs_pkg::NUM_SLOTS'(1) << sel);
    end

    assign is_last    = (mask_clr == '0);
    assign fire       = o_out.valid && o_out.ready;
    assign o_can_load = !o_out.valid || (fire && is_last);

    assign o_out.valid       = |r_mask;
    assign o_out.kind        = r_slot[sel].kind;
    assign o_out.data_byte   = r_slot[sel].data_byte;
    assign o_out.field_index = r_slot[sel].field_index;
    assign o_out.status      = r_slot[sel].status;
    assign o_out.last        = is_last;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_bundle.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_bundle.mask;
        end else if (fire) begin
            r_mask <= mask_clr;
        end
    end

endmodule

`default_nettype wire

[src/quoted_field_splitter_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port             Dir  Width  Transaction
// i_in             in   9      one line byte plus end-of-line mark
// o_out            out  21     one result: kind, data, field index, status, last
// i_cfg_wr_*       in   8      expected field count, written when idle
//
// A byte is taken every cycle while it yields at most one result and the output is ready.
// A byte yielding n results holds the input while the six-slot
// result register drains one result per cycle.
// Synchronous active-low reset; expected field count resets to 1.
// Output stall holds the result register; input is taken on its last result.

module quoted_field_splitter_top #(
    parameter int FIELD_INDEX_BITS = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire  [7:0] i_cfg_wr_data,
    qfs_in_if.sink     i_in,
    qfs_out_if.source  o_out
);

    qfs_pkg::t_bundle bundle;
    logic             can_load;
    logic             accept;

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    qfs_core #(
        .FIELD_INDEX_BITS (FIELD_INDEX_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_line_byte   (i_in.line_byte),
        .i_end_of_line (i_in.end_of_line),
        .o_bundle      (bundle)
    );

    qfs_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_bundle   (bundle),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int         IDX_BITS  = 8;
    localparam logic [7:0] FIELD_TOP = 8'((1 << IDX_BITS) - 1);

    typedef struct packed {
        logic [7:0] b;
        logic       eol;
    } t_line_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] idx;
        logic [1:0] status;
        logic       last;
    } t_split_result;

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_en = 1'b0;
    logic [7:0] cfg_data = 8'h00;
    logic       drv_valid = 1'b0;
    logic [7:0] drv_byte = 8'h00;
    logic       drv_eol = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_taken = 1'b0;
    bit         steady = 1'b0;
    bit         hold_input = 1'b0;

    t_line_item    pending[$];
    t_split_result results_due[$];
    t_split_result step_buf[$];
    logic [7:0]    line_buf[$];

    int errors = 0;
    int bytes_sent = 0;
    int bytes_queued = 0;
    int lines_sent = 0;
    int results_checked = 0;
    int settings_used = 1;

    logic [7:0] exp_fields;
    logic [7:0] st_prev, st_pend, st_held, st_count;
    logic       st_pend_ok, st_skip, st_quoted, st_held_ok, st_qfollow;

    qfs_in_if  byte_if ();
    qfs_out_if res_if ();

    assign byte_if.valid       = drv_valid;
    assign byte_if.line_byte   = drv_byte;
    assign byte_if.end_of_line = drv_eol;
    assign res_if.ready        = out_ready;

    quoted_field_splitter_top #(
        .FIELD_INDEX_BITS(IDX_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_en),
        .i_cfg_wr_data(cfg_data),
        .i_in         (byte_if),
        .o_out        (res_if)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    task automatic emit(input logic [1:0] k, input logic [7:0] d, input logic [1:0] s);
        t_split_result r;
        r.kind   = k;
        r.data   = d;
        r.idx    = st_count;
        r.status = s;
        r.last   = 1'b0;
        step_buf = {step_buf, r};
    endtask

    task automatic clear_line();
        st_prev    = qfs_pkg::SEMI;
        st_pend    = 8'h00;
        st_pend_ok = 1'b0;
        st_skip    = 1'b1;
        st_quoted  = 1'b0;
        st_held    = 8'h00;
        st_held_ok = 1'b0;
        st_count   = 8'h00;
        st_qfollow = 1'b0;
    endtask

    task automatic judge_byte(input logic [7:0] c, input logic [7:0] nxt, input logic nxt_end);
        logic semi_next;
        logic is_delim;
        semi_next = nxt_end || (nxt == qfs_pkg::SEMI);
        if (st_qfollow) begin
            st_qfollow = 1'b0;
            is_delim   = (c == qfs_pkg::QUOTE) && st_quoted && semi_next;
        end else begin
            is_delim = (c == qfs_pkg::QUOTE) && ((st_prev == qfs_pkg::SEMI) || semi_next);
        end
        st_prev = c;
        if (is_delim) begin
            st_quoted  = !st_quoted;
            st_qfollow = 1'b1;
        end else begin
            if (st_held_ok) begin
                emit(qfs_pkg::KIND_CONTENT, st_held, qfs_pkg::STATUS_OK);
                st_held_ok = 1'b0;
            end
            if ((c == qfs_pkg::SEMI) && !st_quoted) begin
                emit(qfs_pkg::KIND_FIELD_END, 8'h00, qfs_pkg::STATUS_OK);
                if (st_count != FIELD_TOP) st_count++;
            end else begin
                st_held    = c;
                st_held_ok = 1'b1;
            end
        end
    endtask

    task automatic close_line();
        logic [7:0] count;
        if (st_held_ok && !st_quoted) emit(qfs_pkg::KIND_CONTENT, st_held, qfs_pkg::STATUS_OK);
        st_held_ok = 1'b0;
        count = (st_count != FIELD_TOP) ? st_count + 8'd1 : FIELD_TOP;
        emit(qfs_pkg::KIND_LINE_END, 8'h00,
             (count == exp_fields) ? qfs_pkg::STATUS_OK : qfs_pkg::STATUS_COUNT);
        clear_line();
    endtask

    task automatic split_step(input logic [7:0] b, input logic eol);
        step_buf.delete();
        if (st_skip) begin
            if (b == qfs_pkg::SEMI) begin
                st_skip = 1'b0;
                st_prev = qfs_pkg::SEMI;
            end
            if (eol) begin
                if (st_skip) begin
                    st_count = 8'h00;
                    emit(qfs_pkg::KIND_LINE_END, 8'h00, qfs_pkg::STATUS_NO_DELIM);
                    clear_line();
                end else begin
                    close_line();
                end
            end
        end else begin
            if (st_pend_ok) judge_byte(st_pend, b, 1'b0);
            st_pend    = b;
            st_pend_ok = 1'b1;
            if (eol) begin
                judge_byte(st_pend, 8'h00, 1'b1);
                st_pend_ok = 1'b0;
                close_line();
            end
        end
        if (step_buf.size() != 0) step_buf[step_buf.size() - 1].last = 1'b1;
        results_due = {results_due, step_buf};
    endtask

    always @(negedge i_clk) begin
        t_line_item it;
        if (!drv_valid || in_taken) begin
            if (rst_n && !hold_input && pending.size() != 0
                    && (steady || $urandom_range(99) >= 33)) begin
                it = pending.pop_front();
                drv_valid <= 1'b1;
                drv_byte  <= it.b;
                drv_eol   <= it.eol;
                split_step(it.b, it.eol);
                bytes_sent++;
            end else begin
                drv_valid <= 1'b0;
            end
        end
        out_ready <= steady || ($urandom_range(99) >= 33);
    end

    always @(posedge i_clk) begin
        t_split_result want;
        in_taken <= drv_valid && byte_if.ready;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing outstanding, kind", res_if.kind, 0);
            end else begin
                want = results_due.pop_front();
                results_checked++;
                if (res_if.kind !== want.kind)
                    report_mismatch("kind", res_if.kind, want.kind);
                if (res_if.data_byte !== want.data)
                    report_mismatch("data_byte", res_if.data_byte, want.data);
                if (res_if.field_index !== want.idx)
                    report_mismatch("field_index", res_if.field_index, want.idx);
                if (res_if.status !== want.status)
                    report_mismatch("status", res_if.status, want.status);
                if (res_if.last !== want.last)
                    report_mismatch("last", res_if.last, want.last);
            end
        end
    end

    task automatic add_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endtask

    task automatic post_line();
        t_line_item it;
        foreach (line_buf[i]) begin
            it.b   = line_buf[i];
            it.eol = (i == line_buf.size() - 1);
            pending = {pending, it};
        end
        bytes_queued += line_buf.size();
        lines_sent++;
        line_buf.delete();
    endtask

    task automatic put_text(input string s);
        foreach (s[i]) add_byte(s[i]);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        if ($urandom_range(9) < 7) begin
            b = 8'h61 + 8'($urandom_range(25));
        end else begin
            b = 8'($urandom_range(255));
            if ((b == qfs_pkg::SEMI) || (b == qfs_pkg::QUOTE)) b = 8'h5F;
        end
        return b;
    endfunction

    function automatic logic [7:0] quoted_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0) return qfs_pkg::SEMI;
        if (r == 1) return qfs_pkg::QUOTE;
        return plain_byte();
    endfunction

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(3);
        if (r == 0) return qfs_pkg::SEMI;
        if (r == 1) return qfs_pkg::QUOTE;
        return 8'($urandom_range(255));
    endfunction

    task automatic build_record(input int nf);
        int f;
        int sel;
        int len;
        repeat ($urandom_range(3)) add_byte(plain_byte());
        add_byte(qfs_pkg::SEMI);
        for (f = 0; f < nf; f++) begin
            if (f != 0) add_byte(qfs_pkg::SEMI);
            sel = $urandom_range(9);
            len = $urandom_range(4);
            if (sel <= 4) begin
                repeat (len) add_byte(plain_byte());
            end else if (sel <= 7) begin
                add_byte(qfs_pkg::QUOTE);
                repeat (len) add_byte(quoted_byte());
                add_byte(qfs_pkg::QUOTE);
            end else if (sel == 8) begin
                repeat (len) add_byte(plain_byte());
                add_byte(qfs_pkg::QUOTE);
                repeat ($urandom_range(3)) add_byte(quoted_byte());
                add_byte(qfs_pkg::QUOTE);
            end else begin
                add_byte(qfs_pkg::QUOTE);
                repeat (len) add_byte(quoted_byte());
                if (f != nf - 1) add_byte(qfs_pkg::QUOTE);
            end
        end
        post_line();
    endtask

    task automatic build_long(input int nf);
        add_byte(8'h4C);
        add_byte(qfs_pkg::SEMI);
        repeat (nf - 1) add_byte(qfs_pkg::SEMI);
        add_byte(8'h7A);
        post_line();
    endtask

    task automatic random_lines(input int budget, input int maxf);
        int stop_at;
        int sel;
        int target;
        stop_at = bytes_queued + budget;
        target  = (exp_fields == 0) ? 1 : int'(exp_fields);
        while (bytes_queued < stop_at) begin
            sel = $urandom_range(9);
            if (sel < 7) begin
                build_record($urandom_range(1) ? target : $urandom_range(maxf, 1));
            end else if (sel == 7) begin
                repeat ($urandom_range(8, 1)) add_byte(noise_byte());
                post_line();
            end else if (sel == 8) begin
                repeat ($urandom_range(4, 1)) add_byte(plain_byte());
                post_line();
            end else begin
                repeat ($urandom_range(4, 1)) add_byte(qfs_pkg::SEMI);
                post_line();
            end
        end
    endtask

    task automatic settle();
        int spin;
        spin = 0;
        while ((pending.size() != 0 || drv_valid || results_due.size() != 0) && spin < 20000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_expected(input logic [7:0] v);
        settle();
        @(negedge i_clk);
        cfg_en   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_en   <= 1'b0;
        exp_fields = v;
        settings_used++;
    endtask

    initial begin
        clear_line();
        exp_fields = 8'd1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        put_text("A");
        post_line();
        add_byte(8'hFF);
        add_byte(8'h00);
        post_line();
        put_text(";");
        post_line();
        put_text("N;\"a;b\"");
        post_line();
        put_text(";x;y");
        post_line();
        put_text(";\"\"");
        post_line();
        put_text(";ab\"c");
        post_line();
        put_text(";\"x");
        post_line();
        add_byte(qfs_pkg::SEMI);
        add_byte(8'h00);
        add_byte(qfs_pkg::SEMI);
        post_line();

        set_expected(8'd3);
        random_lines(40, 5);
        while (pending.size() > 10) @(posedge i_clk);
        hold_input = 1'b1;
        while (results_due.size() != 0 || drv_valid) @(posedge i_clk);
        hold_input = 1'b0;

        set_expected(8'd0);
        random_lines(20, 3);

        set_expected(FIELD_TOP);
        steady = 1'b1;
        build_long(258);

        set_expected(8'd1);
        random_lines(30, 3);

        set_expected(8'($urandom_range(8, 2)));
        steady = 1'b0;
        random_lines(30, 9);

        settle();
        if (results_due.size() != 0)
            report_mismatch("results never delivered, count", 0, results_due.size());
        $display("Sent %0d line bytes in %0d lines under %0d field-count settings.",
                 bytes_sent, lines_sent, settings_used);
        $display("Checked %0d results, %0d mismatches.", results_checked, errors);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
